>>> rtl/core/cbpf_pkg.sv
// Package with shared types, constants and the covalent radius table.
package cbpf_pkg;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned ElemW   = 4;
  localparam int unsigned PosW    = 31;
  localparam int unsigned StatusW = 2;
  localparam int unsigned IdxOutW = 11;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 21;
  localparam int unsigned LimitW  = 12;
  localparam int unsigned MinDW   = 21;
  localparam int unsigned ScaleW  = 12;
  localparam int unsigned RadW    = 12;
  localparam int unsigned FracBits = 10;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_REQUEST = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_ACCEPTED = 2'd0,
    ST_BOND     = 2'd1,
    ST_NO_MORE  = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ATOM_LIMIT = 2'd0,
    REG_MIN_DIST   = 2'd1,
    REG_SCALE      = 2'd2,
    REG_DEF_RADIUS = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIFF,
    S_SQUARE,
    S_SUM,
    S_TEST,
    S_RESULT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write_atom;
    logic clear_total;
    logic restart_scan;
    logic load_scan;
    logic issue_read;
    logic stage_diff;
    logic stage_square;
    logic stage_sum;
    logic advance;
    logic save_scan;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic over_limit;
    logic scan_done;
    logic is_bond;
  } dp_stat_t;

  function automatic logic [RadW-1:0] table_radius(input logic [ElemW-1:0] code,
                                                   input int unsigned frac);
    logic [7:0] h;
    logic [31:0] v;
    case (code)
      4'd0:  h = 8'd31;
      4'd1:  h = 8'd84;
      4'd2:  h = 8'd76;
      4'd3:  h = 8'd71;
      4'd4:  h = 8'd66;
      4'd5:  h = 8'd57;
      4'd6:  h = 8'd111;
      4'd7:  h = 8'd107;
      4'd8:  h = 8'd105;
      4'd9:  h = 8'd102;
      4'd10: h = 8'd132;
      4'd11: h = 8'd132;
      4'd12: h = 8'd122;
      4'd13: h = 8'd120;
      4'd14: h = 8'd139;
      default: h = 8'd0;
    endcase
    v = (32'(h) * (32'd1 << frac) + 32'd50) / 32'd100;
    return v[RadW-1:0];
  endfunction

  function automatic logic [16*RadW-1:0] radius_table(input int unsigned frac);
    logic [16*RadW-1:0] t;
    t = '0;
    for (int i = 0; i < 15; i++) begin
      t[i*RadW +: RadW] = table_radius(ElemW'(i), frac);
    end
    return t;
  endfunction

  // Table radii packed by element code; the slot for code 15 is unused.
  localparam logic [16*RadW-1:0] RadiusTable = radius_table(FracBits);

endpackage

>>> rtl/core/cbpf_if.sv
// Valid/ready channel interface for the input and result streams.
interface cbpf_in_if;
  logic                       valid;
  logic                       ready;
  logic [cbpf_pkg::CmdW-1:0]  command;
  logic [cbpf_pkg::ElemW-1:0] element_code;
  logic signed [cbpf_pkg::PosW-1:0] pos_x;
  logic signed [cbpf_pkg::PosW-1:0] pos_y;
  logic signed [cbpf_pkg::PosW-1:0] pos_z;
  modport source (output valid, command, element_code, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, command, element_code, pos_x, pos_y, pos_z, output ready);
endinterface

interface cbpf_out_if;
  logic                         valid;
  logic                         ready;
  logic [cbpf_pkg::StatusW-1:0] status;
  logic [cbpf_pkg::IdxOutW-1:0] first_atom;
  logic [cbpf_pkg::IdxOutW-1:0] second_atom;
  modport source (output valid, status, first_atom, second_atom, input ready);
  modport sink (input valid, status, first_atom, second_atom, output ready);
endinterface

>>> rtl/core/cbpf_datapath.sv
// Datapath: atom memories, scan indexes and the pipelined pair distance test.
module cbpf_datapath #(
  parameter int unsigned MAX_ATOMS = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cbpf_pkg::dp_cmd_t             cmd_i,
  output cbpf_pkg::dp_stat_t            stat_o,
  input  logic [cbpf_pkg::ElemW-1:0]    elem_i,
  input  logic signed [cbpf_pkg::PosW-1:0] pos_x_i,
  input  logic signed [cbpf_pkg::PosW-1:0] pos_y_i,
  input  logic signed [cbpf_pkg::PosW-1:0] pos_z_i,
  input  logic                          cfg_we_i,
  input  logic [cbpf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cbpf_pkg::CfgDataW-1:0] cfg_data_i,
  output logic [cbpf_pkg::IdxOutW-1:0]  first_o,
  output logic [cbpf_pkg::IdxOutW-1:0]  second_o
);
  import cbpf_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ATOMS);
  localparam int unsigned NW = $clog2(MAX_ATOMS + 1);
  localparam int unsigned DW = PosW + 1;
  localparam int unsigned SqW = 2 * DW;
  localparam int unsigned D2W = SqW + 2;
  localparam int unsigned CW = ScaleW + RadW + 1;
  localparam int unsigned LimW = 2 * CW;
  localparam int unsigned CmpW = ((NW > LimitW) ? NW : LimitW) + 1;

  logic [ElemW-1:0] elem_mem [MAX_ATOMS];
  logic signed [PosW-1:0] x_mem [MAX_ATOMS];
  logic signed [PosW-1:0] y_mem [MAX_ATOMS];
  logic signed [PosW-1:0] z_mem [MAX_ATOMS];

  logic [NW-1:0] total_q;
  logic [NW-1:0] first_q, second_q, f_q, s_q;
  logic [LimitW-1:0] limit_q;
  logic [MinDW-1:0] mind_q;
  logic [ScaleW-1:0] scale_q;
  logic [RadW-1:0] defr_q;

  logic [ElemW-1:0] ea_q, eb_q;
  logic signed [PosW-1:0] xa_q, xb_q, ya_q, yb_q, za_q, zb_q;
  logic [DW-1:0] dx_q, dy_q, dz_q;
  logic [CW-1:0] c_q;
  logic [SqW-1:0] sx_q, sy_q, sz_q;
  logic [LimW-1:0] lim_q;
  logic [D2W-1:0] d2_q;

  logic [NW-1:0] s_scan, f_inc;
  logic [RadW-1:0] ra, rb;
  logic signed [DW-1:0] ddx, ddy, ddz;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_atom) begin
      elem_mem[total_q[AW-1:0]] <= elem_i;
      x_mem[total_q[AW-1:0]] <= pos_x_i;
      y_mem[total_q[AW-1:0]] <= pos_y_i;
      z_mem[total_q[AW-1:0]] <= pos_z_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue_read) begin
      ea_q <= elem_mem[f_q[AW-1:0]];
      xa_q <= x_mem[f_q[AW-1:0]];
      ya_q <= y_mem[f_q[AW-1:0]];
      za_q <= z_mem[f_q[AW-1:0]];
      eb_q <= elem_mem[s_q[AW-1:0]];
      xb_q <= x_mem[s_q[AW-1:0]];
      yb_q <= y_mem[s_q[AW-1:0]];
      zb_q <= z_mem[s_q[AW-1:0]];
    end
  end

  assign ra = (ea_q == 4'd15) ? defr_q : RadiusTable[RadW*ea_q +: RadW];
  assign rb = (eb_q == 4'd15) ? defr_q : RadiusTable[RadW*eb_q +: RadW];
  assign ddx = DW'(xa_q) - DW'(xb_q);
  assign ddy = DW'(ya_q) - DW'(yb_q);
  assign ddz = DW'(za_q) - DW'(zb_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.stage_diff) begin
      dx_q <= ddx[DW-1] ? DW'(-ddx) : DW'(ddx);
      dy_q <= ddy[DW-1] ? DW'(-ddy) : DW'(ddy);
      dz_q <= ddz[DW-1] ? DW'(-ddz) : DW'(ddz);
      c_q <= CW'(scale_q) * (CW'(ra) + CW'(rb));
    end
    if (cmd_i.stage_square) begin
      sx_q <= SqW'(dx_q) * SqW'(dx_q);
      sy_q <= SqW'(dy_q) * SqW'(dy_q);
      sz_q <= SqW'(dz_q) * SqW'(dz_q);
      lim_q <= (LimW'(c_q) * LimW'(c_q)) >> (2 * FracBits);
    end
    if (cmd_i.stage_sum) begin
      d2_q <= D2W'(sx_q) + D2W'(sy_q) + D2W'(sz_q);
    end
  end

  // Next scan position before reading: second is lifted above first, and a
  // second index past the last atom moves the scan on to the next first atom.
  assign s_scan = (second_q <= first_q) ? first_q + NW'(1) : second_q;
  assign f_inc = f_q + NW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      first_q  <= '0;
      second_q <= NW'(1);
      f_q      <= '0;
      s_q      <= NW'(1);
      limit_q  <= LimitW'(1500);
      mind_q   <= MinDW'(10486);
      scale_q  <= ScaleW'(1249);
      defr_q   <= RadW'(870);
    end else begin
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_idx_i))
          REG_ATOM_LIMIT: limit_q <= cfg_data_i[LimitW-1:0];
          REG_MIN_DIST:   mind_q  <= cfg_data_i[MinDW-1:0];
          REG_SCALE:      scale_q <= cfg_data_i[ScaleW-1:0];
          REG_DEF_RADIUS: defr_q  <= cfg_data_i[RadW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.write_atom) total_q <= total_q + NW'(1);
      if (cmd_i.clear_total) total_q <= '0;
      if (cmd_i.restart_scan) begin
        first_q  <= '0;
        second_q <= NW'(1);
      end
      if (cmd_i.load_scan) begin
        if ((first_q + NW'(1) < total_q) && !(s_scan < total_q)) begin
          f_q <= first_q + NW'(1);
          s_q <= first_q + NW'(2);
        end else begin
          f_q <= first_q;
          s_q <= s_scan;
        end
      end
      if (cmd_i.advance) begin
        if (s_q + NW'(1) < total_q) begin
          s_q <= s_q + NW'(1);
        end else begin
          f_q <= f_inc;
          s_q <= f_inc + NW'(1);
        end
      end
      if (cmd_i.save_scan) begin
        first_q  <= f_q;
        second_q <= stat_o.is_bond ? s_q + NW'(1) : s_q;
      end
    end
  end

  always_comb begin
    stat_o.full       = (total_q >= NW'(MAX_ATOMS));
    stat_o.over_limit = (CmpW'(total_q) > CmpW'(limit_q));
    stat_o.scan_done  = !(f_q + NW'(1) < total_q) || !(s_q < total_q);
    stat_o.is_bond    = (d2_q > D2W'(mind_q)) && ({2'b0, d2_q} <= (D2W + 2)'(lim_q));
  end

  assign first_o  = IdxOutW'(f_q);
  assign second_o = IdxOutW'(s_q);

endmodule

>>> rtl/core/cbpf_ctrl.sv
// Controller state machine that sequences loads, clears and the pair scan.
module cbpf_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [cbpf_pkg::CmdW-1:0]    in_cmd_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [cbpf_pkg::StatusW-1:0] status_o,
  output logic                         hold_idx_o,
  output cbpf_pkg::dp_cmd_t            cmd_o,
  input  cbpf_pkg::dp_stat_t           stat_i
);
  import cbpf_pkg::*;

  state_e state_q, state_d;
  status_e status_q, status_d;
  logic hold_q, hold_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_ACCEPTED;
      hold_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      hold_q   <= hold_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    hold_d   = hold_q;
    cmd_o    = '0;
    in_ready_o  = (state_q == S_IDLE);
    out_valid_o = (state_q == S_RESULT);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          hold_d   = 1'b0;
          status_d = ST_ACCEPTED;
          state_d  = S_RESULT;
          unique case (cmd_e'(in_cmd_i))
            CMD_LOAD: begin
              if (stat_i.full) begin
                status_d = ST_FULL;
              end else begin
                cmd_o.write_atom   = 1'b1;
                cmd_o.restart_scan = 1'b1;
              end
            end
            CMD_CLEAR: begin
              cmd_o.clear_total  = 1'b1;
              cmd_o.restart_scan = 1'b1;
            end
            CMD_REQUEST: begin
              if (stat_i.over_limit) begin
                status_d = ST_NO_MORE;
              end else begin
                cmd_o.load_scan = 1'b1;
                state_d = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (stat_i.scan_done) begin
          cmd_o.save_scan = 1'b1;
          status_d = ST_NO_MORE;
          state_d  = S_RESULT;
        end else begin
          cmd_o.issue_read = 1'b1;
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd_o.stage_diff = 1'b1;
        state_d = S_SQUARE;
      end
      S_SQUARE: begin
        cmd_o.stage_square = 1'b1;
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.stage_sum = 1'b1;
        state_d = S_TEST;
      end
      S_TEST: begin
        if (stat_i.is_bond) begin
          cmd_o.save_scan = 1'b1;
          status_d = ST_BOND;
          hold_d   = 1'b1;
          state_d  = S_RESULT;
        end else begin
          cmd_o.advance = 1'b1;
          state_d = S_READ;
        end
      end
      S_RESULT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign status_o   = status_q;
  assign hold_idx_o = hold_q;

endmodule

>>> rtl/core/covalent_bond_pair_finder.sv
// Top level of the covalent bond pair finder.
// Each transaction is answered with one result. A load, clear, unused command
// or rejected request is answered in the cycle after it is taken. A bond
// request tests the atom pairs one at a time, each through the memory read,
// difference, squaring, sum and compare states, until it finds a bond or runs
// out of pairs. No new transaction is taken until the result has been taken.
module covalent_bond_pair_finder #(
  parameter int unsigned MAX_ATOMS = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cbpf_in_if.sink                       in_if,
  cbpf_out_if.source                    out_if,
  input  logic                          cfg_we_i,
  input  logic [cbpf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cbpf_pkg::CfgDataW-1:0] cfg_data_i
);
  import cbpf_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic hold_idx;
  logic [IdxOutW-1:0] first_idx, second_idx;

  cbpf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .in_cmd_i    (in_if.command),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .status_o    (out_if.status),
    .hold_idx_o  (hold_idx),
    .cmd_o       (dp_cmd),
    .stat_i      (dp_stat)
  );

  cbpf_datapath #(.MAX_ATOMS(MAX_ATOMS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat),
    .elem_i     (in_if.element_code),
    .pos_x_i    (in_if.pos_x),
    .pos_y_i    (in_if.pos_y),
    .pos_z_i    (in_if.pos_z),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .first_o    (first_idx),
    .second_o   (second_idx)
  );

  assign out_if.first_atom  = hold_idx ? first_idx : '0;
  assign out_if.second_atom = hold_idx ? second_idx : '0;

endmodule

>>> rtl/core/cbpf_checker.sv
// Port-level checker for the bond pair finder and its bind statement.
module cbpf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [cbpf_pkg::StatusW-1:0] status,
  input logic [cbpf_pkg::IdxOutW-1:0] first_atom,
  input logic [cbpf_pkg::IdxOutW-1:0] second_atom
);
  import cbpf_pkg::*;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid)) else $error("input taken while a result is pending");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready) else $error("input taken twice");

  a_bond_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && status == ST_BOND) |-> (first_atom < second_atom))
    else $error("bond indexes out of order");

  a_zero_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && status != ST_BOND) |-> (first_atom == '0 && second_atom == '0))
    else $error("indexes set without a bond");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(status)))
    else $error("result dropped while stalled");

endmodule

bind covalent_bond_pair_finder cbpf_checker u_cbpf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .status      (out_if.status),
  .first_atom  (out_if.first_atom),
  .second_atom (out_if.second_atom)
);

>>> tb/covalent_bond_pair_finder_tb.sv
// Self-checking testbench for the covalent bond pair finder with a predictor of its own.
`timescale 1ns / 1ps

module covalent_bond_pair_finder_tb;
  import cbpf_pkg::*;

  localparam int unsigned NumAtoms = 2048;

  typedef struct packed {
    status_e             status;
    logic [IdxOutW-1:0]  first_atom;
    logic [IdxOutW-1:0]  second_atom;
  } bond_result_t;

  logic clk_i;
  logic rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  cbpf_in_if  in_ch ();
  cbpf_out_if out_ch ();

  covalent_bond_pair_finder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch.sink),
    .out_if     (out_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor state.
  logic [ElemW-1:0] elem_mem [NumAtoms];
  int               xpos_mem [NumAtoms];
  int               ypos_mem [NumAtoms];
  int               zpos_mem [NumAtoms];
  int unsigned      atoms_held;
  int unsigned      scan_lo;
  int unsigned      scan_hi;
  int unsigned      limit_reg;
  int unsigned      min_d2_reg;
  int unsigned      scale_reg;
  int unsigned      def_radius_reg;
  int unsigned      radius_centi [15] = '{31, 84, 76, 71, 66, 57, 111, 107, 105, 102,
                                          132, 132, 122, 120, 139};

  bond_result_t expected_bonds [$];
  int unsigned  mismatches;
  bit           idle_enable;
  int unsigned  out_stall;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic longint unsigned atom_radius(logic [ElemW-1:0] code);
    if (code < 15) return (longint'(radius_centi[code]) * (64'd1 << FracBits) + 50) / 100;
    return def_radius_reg;
  endfunction

  function automatic longint unsigned axis_sq(int a, int b);
    longint d;
    longint unsigned m;
    d = longint'(a) - longint'(b);
    m = (d < 0) ? longint'(-d) : longint'(d);
    return m * m;
  endfunction

  function automatic bit pair_bonded(int unsigned a, int unsigned b);
    longint unsigned d2;
    longint unsigned c;
    longint unsigned lim;
    d2 = axis_sq(xpos_mem[a], xpos_mem[b]) + axis_sq(ypos_mem[a], ypos_mem[b])
       + axis_sq(zpos_mem[a], zpos_mem[b]);
    c = longint'(scale_reg) * (atom_radius(elem_mem[a]) + atom_radius(elem_mem[b]));
    lim = (c * c) >> (2 * FracBits);
    return (d2 > longint'(min_d2_reg)) && (d2 <= lim);
  endfunction

  function automatic bond_result_t predict_bond(cmd_e cmd, logic [ElemW-1:0] elem,
                                                logic signed [PosW-1:0] x,
                                                logic signed [PosW-1:0] y,
                                                logic signed [PosW-1:0] z);
    bond_result_t r;
    int unsigned f;
    int unsigned s;
    r = '{ST_ACCEPTED, '0, '0};
    case (cmd)
      CMD_LOAD: begin
        if (atoms_held >= NumAtoms) begin
          r.status = ST_FULL;
        end else begin
          elem_mem[atoms_held] = elem;
          xpos_mem[atoms_held] = int'(x);
          ypos_mem[atoms_held] = int'(y);
          zpos_mem[atoms_held] = int'(z);
          atoms_held++;
          scan_lo = 0;
          scan_hi = 1;
        end
      end
      CMD_CLEAR: begin
        atoms_held = 0;
        scan_lo = 0;
        scan_hi = 1;
      end
      CMD_REQUEST: begin
        r.status = ST_NO_MORE;
        if (atoms_held <= limit_reg) begin
          f = scan_lo;
          s = scan_hi;
          while (f + 1 < atoms_held) begin
            if (s <= f) s = f + 1;
            while (s < atoms_held) begin
              if (pair_bonded(f, s)) begin
                scan_lo = f;
                scan_hi = s + 1;
                r = '{ST_BOND, f[IdxOutW-1:0], s[IdxOutW-1:0]};
                return r;
              end
              s++;
            end
            f++;
            s = f + 1;
          end
          scan_lo = f;
          scan_hi = s;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(cmd_e cmd, logic [ElemW-1:0] elem, int x, int y, int z);
    while (idle_enable && $urandom_range(99) < 19) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    expected_bonds.insert(expected_bonds.size(),
                          predict_bond(cmd, elem, x[PosW-1:0], y[PosW-1:0], z[PosW-1:0]));
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.element_code <= elem;
    in_ch.pos_x        <= x[PosW-1:0];
    in_ch.pos_y        <= y[PosW-1:0];
    in_ch.pos_z        <= z[PosW-1:0];
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_atom(logic [ElemW-1:0] elem, int x, int y, int z);
    send_item(CMD_LOAD, elem, x, y, z);
  endtask

  task automatic send_cmd(cmd_e cmd);
    send_item(cmd, 4'($urandom), int'($urandom), int'($urandom), int'($urandom));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_bonds.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, int unsigned value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CfgDataW-1:0];
    @(posedge clk_i);
    case (idx)
      REG_ATOM_LIMIT: limit_reg      = value & 32'hFFF;
      REG_MIN_DIST:   min_d2_reg     = value & 32'h1FFFFF;
      REG_SCALE:      scale_reg      = value & 32'hFFF;
      default:        def_radius_reg = value & 32'hFFF;
    endcase
  endtask

  task automatic set_regs(int unsigned lim, int unsigned mind, int unsigned scl,
                          int unsigned rad);
    drain_results();
    write_reg(REG_ATOM_LIMIT, lim);
    write_reg(REG_MIN_DIST, mind);
    write_reg(REG_SCALE, scl);
    write_reg(REG_DEF_RADIUS, rad);
    cfg_we_i <= 1'b0;
  endtask

  // Clears the store, loads a cluster of atoms about one bond length apart, then asks for bonds.
  task automatic run_cluster(int unsigned n, int unsigned reqs, int unsigned spread);
    int bx;
    int by;
    int bz;
    bx = int'($urandom_range(2000000)) - 1000000;
    by = int'($urandom_range(2000000)) - 1000000;
    bz = int'($urandom_range(2000000)) - 1000000;
    send_cmd(CMD_CLEAR);
    repeat (n) begin
      send_atom(4'($urandom_range(15)), bx + int'($urandom_range(spread)),
                by + int'($urandom_range(spread)), bz + int'($urandom_range(spread)));
    end
    repeat (reqs) send_cmd(CMD_REQUEST);
  endtask

  // Result checker and receiver.
  initial begin
    bond_result_t exp_r;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bonds.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result status=%0d", out_ch.status);
        end else begin
          exp_r = expected_bonds.pop_front();
          if (out_ch.status !== exp_r.status || out_ch.first_atom !== exp_r.first_atom ||
              out_ch.second_atom !== exp_r.second_atom) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected %0d (%0d,%0d), actual %0d (%0d,%0d)",
                       exp_r.status, exp_r.first_atom, exp_r.second_atom,
                       out_ch.status, out_ch.first_atom, out_ch.second_atom);
          end
        end
      end
      if (out_stall != 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(idle_enable && $urandom_range(99) < 19);
      end
    end
  end

  task automatic test_directed();
    send_cmd(CMD_REQUEST);
    send_atom(4'd0, 0, 0, 0);
    send_atom(4'd0, 758, 0, 0);
    send_atom(4'd2, 0, 1100, 0);
    send_atom(4'd15, 0, 0, 1000);
    send_atom(4'd14, 1024000000, -1024000000, 1024000000);
    send_atom(4'd8, -1024000000, 1024000000, -1024000000);
    send_atom(4'd4, 0, 0, 0);
    repeat (8) send_cmd(CMD_REQUEST);
    send_cmd(CMD_NONE);
    send_cmd(CMD_REQUEST);
    send_atom(4'd9, 32'h3FFF_FFFF, 32'h4000_0000, 1);
    send_cmd(CMD_REQUEST);
    send_cmd(CMD_CLEAR);
    send_cmd(CMD_REQUEST);
  endtask

  task automatic test_config_extremes();
    set_regs(0, 0, 4095, 4095);
    run_cluster(3, 2, 3000);
    set_regs(1, 1048576, 4095, 0);
    run_cluster(3, 2, 1500);
    set_regs(4095, 2097151, 0, 4095);
    run_cluster(4, 3, 2000);
    set_regs(2048, 0, 2000, 0);
    run_cluster(6, 8, 2500);
  endtask

  task automatic test_store_full();
    set_regs(1500, 10486, 1249, 870);
    send_cmd(CMD_CLEAR);
    repeat (NumAtoms) begin
      send_atom(4'($urandom), int'($urandom), int'($urandom), int'($urandom));
    end
    send_atom(4'd1, 0, 0, 0);
    send_cmd(CMD_REQUEST);
    send_cmd(CMD_CLEAR);
  endtask

  task automatic test_backpressure();
    drain_results();
    out_stall = 300;
    run_cluster(10, 10, 3000);
    drain_results();
    run_cluster(5, 4, 2500);
  endtask

  task automatic test_random();
    for (int p = 0; p < 5; p++) begin
      idle_enable = (p != 1);
      if (p == 4) set_regs(1500, 10486, 1249, 870);
      else set_regs($urandom_range(40), $urandom_range(20000), $urandom_range(900, 2500),
                    $urandom_range(4095));
      for (int k = 0; k < 300; ) begin
        if ($urandom_range(9) == 0) begin
          case ($urandom_range(2))
            0: send_cmd(CMD_NONE);
            1: send_atom(4'($urandom), int'($urandom), int'($urandom), int'($urandom));
            default: send_cmd(CMD_REQUEST);
          endcase
          k++;
        end else begin
          run_cluster($urandom_range(2, 25), $urandom_range(1, 12), $urandom_range(500, 4000));
          k += 20;
        end
      end
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = REG_ATOM_LIMIT;
    cfg_data_i         = '0;
    in_ch.valid        = 1'b0;
    in_ch.command      = CMD_NONE;
    in_ch.element_code = '0;
    in_ch.pos_x        = '0;
    in_ch.pos_y        = '0;
    in_ch.pos_z        = '0;
    out_ch.ready       = 1'b0;
    mismatches         = 0;
    idle_enable        = 1'b1;
    out_stall          = 0;
    atoms_held         = 0;
    scan_lo            = 0;
    scan_hi            = 1;
    limit_reg          = 1500;
    min_d2_reg         = 10486;
    scale_reg          = 1249;
    def_radius_reg     = 870;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_store_full();
    test_backpressure();
    test_random();
    drain_results();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
